// ===== rtl/pufd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pufd_pkg
// Shared types and constants of the percent/UTF-8 filename decoder.
// ----------------------------------------------------------------------------
package pufd_pkg;

  localparam int unsigned LenW = 9;

  localparam logic [2:0] PREFIX_LEN = 3'd7;

  typedef enum logic [2:0] {
    ST_PENDING    = 3'd0,
    ST_ACCEPTED   = 3'd1,
    ST_BAD_PREFIX = 3'd2,
    ST_BAD_ESCAPE = 3'd3,
    ST_FORBIDDEN  = 3'd4,
    ST_TOO_LONG   = 3'd5,
    ST_BAD_UTF8   = 3'd6,
    ST_EMPTY      = 3'd7
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       done_res;
    logic [2:0] status;
  } out_item_t;

  // decode stage view after the current item has been applied
  typedef struct packed {
    logic       emit;
    logic [7:0] dec_byte;
    status_e    err;
    logic       prefix_open;
    logic       esc_open;
    logic       count_zero;
  } dec_res_t;

  // lower-case text of the UTF-8'' prefix
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h75;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h66;
      3'd3:    c = 8'h2d;
      3'd4:    c = 8'h38;
      3'd5:    c = 8'h27;
      3'd6:    c = 8'h27;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) r = b | 8'h20;
    return r;
  endfunction

  // msb set when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b0, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b0, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== rtl/pufd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pufd_decode
// Prefix match, %XX unescape, forbidden byte and length checks.
// ----------------------------------------------------------------------------
module pufd_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [7:0]                    byte_i,
  input  logic                          last_i,
  input  logic [pufd_pkg::LenW-1:0]     max_len_i,
  output pufd_pkg::dec_res_t            res_o
);
  import pufd_pkg::*;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  logic [2:0]      prefix_pos_q, prefix_pos_d;
  logic [1:0]      esc_q, esc_d;
  logic [3:0]      high_q, high_d;
  logic [LenW-1:0] count_q, count_d;
  status_e         err_q, err_d;

  logic       have;
  logic [7:0] dec;
  logic       emit;
  logic [4:0] hex;

  always_comb begin
    prefix_pos_d = prefix_pos_q;
    esc_d        = esc_q;
    high_d       = high_q;
    count_d      = count_q;
    err_d        = err_q;
    have         = 1'b0;
    dec          = 8'h00;
    emit         = 1'b0;
    hex          = hex_value(byte_i);
    if (err_q == ST_PENDING) begin
      if (prefix_pos_q != PREFIX_LEN) begin
        if (fold_case(byte_i) == prefix_char(prefix_pos_q)) begin
          prefix_pos_d = prefix_pos_q + 3'd1;
        end else begin
          err_d = ST_BAD_PREFIX;
        end
      end else if (esc_q == ESC_HIGH) begin
        if (hex[4]) begin
          err_d = ST_BAD_ESCAPE;
        end else begin
          high_d = hex[3:0];
          esc_d  = ESC_LOW;
        end
      end else if (esc_q == ESC_LOW) begin
        if (hex[4]) begin
          err_d = ST_BAD_ESCAPE;
        end else begin
          dec   = {high_q, hex[3:0]};
          have  = 1'b1;
          esc_d = ESC_NONE;
        end
      end else if (byte_i == 8'h25) begin
        esc_d = ESC_HIGH;
      end else begin
        dec  = byte_i;
        have = 1'b1;
      end

      if (have) begin
        if (dec == 8'h00 || dec == 8'h0d || dec == 8'h0a || dec == 8'h7f) begin
          err_d = ST_FORBIDDEN;
        end else if (count_q >= max_len_i) begin
          err_d = ST_TOO_LONG;
        end else begin
          count_d = count_q + 1'b1;
          emit    = 1'b1;
        end
      end
    end
  end

  assign res_o.emit        = emit;
  assign res_o.dec_byte    = emit ? dec : 8'h00;
  assign res_o.err         = err_d;
  assign res_o.prefix_open = (prefix_pos_d != PREFIX_LEN);
  assign res_o.esc_open    = (esc_d != ESC_NONE);
  assign res_o.count_zero  = (count_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_pos_q <= '0;
      esc_q        <= ESC_NONE;
      high_q       <= '0;
      count_q      <= '0;
      err_q        <= ST_PENDING;
    end else if (step_i) begin
      if (last_i) begin
        prefix_pos_q <= '0;
        esc_q        <= ESC_NONE;
        high_q       <= '0;
        count_q      <= '0;
        err_q        <= ST_PENDING;
      end else begin
        prefix_pos_q <= prefix_pos_d;
        esc_q        <= esc_d;
        high_q       <= high_d;
        count_q      <= count_d;
        err_q        <= err_d;
      end
    end
  end

endmodule

// ===== rtl/pufd_utf8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pufd_utf8
// UTF-8 validator over the decoded byte stream.
// ----------------------------------------------------------------------------
module pufd_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       feed_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  output logic       bad_o
);
  import pufd_pkg::*;

  logic [1:0]  rem_q, rem_d;
  logic [1:0]  total_q, total_d;
  logic [20:0] cp_q, cp_d;
  logic        err_q, err_d;

  logic [20:0] cp_next;

  assign cp_next = {cp_q[14:0], byte_i[5:0]};

  always_comb begin
    rem_d   = rem_q;
    total_d = total_q;
    cp_d    = cp_q;
    err_d   = err_q;
    if (feed_i && !err_q) begin
      if (rem_q == 2'd0) begin
        if (byte_i <= 8'h7f) begin
          // plain ascii, nothing to track
        end else if (byte_i >= 8'hc2 && byte_i <= 8'hdf) begin
          cp_d    = {16'h0, byte_i[4:0]};
          total_d = 2'd1;
          rem_d   = 2'd1;
        end else if (byte_i >= 8'he0 && byte_i <= 8'hef) begin
          cp_d    = {17'h0, byte_i[3:0]};
          total_d = 2'd2;
          rem_d   = 2'd2;
        end else if (byte_i >= 8'hf0 && byte_i <= 8'hf4) begin
          cp_d    = {18'h0, byte_i[2:0]};
          total_d = 2'd3;
          rem_d   = 2'd3;
        end else begin
          err_d = 1'b1;
        end
      end else if (byte_i[7:6] != 2'b10) begin
        err_d = 1'b1;
      end else begin
        cp_d  = cp_next;
        rem_d = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          // sequence complete: overlong, surrogate and range checks
          if ((total_q == 2'd2 && cp_next < 21'h000800) ||
              (total_q == 2'd3 && cp_next < 21'h010000) ||
              (cp_next >= 21'h00d800 && cp_next <= 21'h00dfff) ||
              cp_next > 21'h10ffff) begin
            err_d = 1'b1;
          end
        end
      end
    end
  end

  assign bad_o = err_d || (rem_d != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      total_q <= '0;
      cp_q    <= '0;
      err_q   <= 1'b0;
    end else if (clear_i) begin
      rem_q   <= '0;
      total_q <= '0;
      cp_q    <= '0;
      err_q   <= 1'b0;
    end else if (feed_i) begin
      rem_q   <= rem_d;
      total_q <= total_d;
      cp_q    <= cp_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== rtl/percent_utf8_filename_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_utf8_filename_decoder
// Decodes an UTF-8'' extended filename value with %XX escapes and checks
// the decoded bytes as UTF-8.
// ----------------------------------------------------------------------------
// Raw value bytes enter back to back, one item per clock unless stalled, and
// each item gives exactly one result item, via the input and then the result
// register. The per-byte work is a single pass through the prefix/unescape
// checks and the UTF-8 validator, whose state registers update as the item
// moves from the input register into the result register. A stalled output
// holds the result while the input register still takes one more item. The
// result for the byte marked last carries the verdict and clears all state.
// Write max_length through the cfg port while idle; the block does not check.
module percent_utf8_filename_decoder #(
  parameter int unsigned MaxLenReset = 259
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pufd_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pufd_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pufd_pkg::LenW-1:0]     cfg_data_i
);
  import pufd_pkg::*;

  logic [LenW-1:0] max_len_q;
  in_item_t        in_q;
  logic            in_valid_q;
  out_item_t       out_q, res_d;
  logic            out_valid_q;
  logic            adv;
  logic            step;
  dec_res_t        dec;
  logic            utf8_bad;
  status_e         status;

  assign cfg_ready_o = 1'b1;
  assign adv         = !out_valid_q || !out_stall_i;
  assign step        = in_valid_q && adv;
  assign in_stall_o  = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= LenW'(MaxLenReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  pufd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_q.in_byte),
    .last_i    (in_q.last_byte),
    .max_len_i (max_len_q),
    .res_o     (dec)
  );

  pufd_utf8 u_utf8 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .feed_i  (step && dec.emit),
    .clear_i (step && in_q.last_byte),
    .byte_i  (dec.dec_byte),
    .bad_o   (utf8_bad)
  );

  // verdict ranking: decode error, open prefix, open escape, utf8, empty
  always_comb begin
    status = ST_PENDING;
    if (in_q.last_byte) begin
      if (dec.err != ST_PENDING) status = dec.err;
      else if (dec.prefix_open)  status = ST_BAD_PREFIX;
      else if (dec.esc_open)     status = ST_BAD_ESCAPE;
      else if (utf8_bad)         status = ST_BAD_UTF8;
      else if (dec.count_zero)   status = ST_EMPTY;
      else                       status = ST_ACCEPTED;
    end
  end

  assign res_d.out_valid = dec.emit;
  assign res_d.out_byte  = dec.dec_byte;
  assign res_d.done_res  = in_q.last_byte;
  assign res_d.status    = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_done_has_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> out_data_o.status != ST_PENDING)
    else $error("final item without verdict");

  a_pending_unless_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |-> out_data_o.status == ST_PENDING)
    else $error("verdict on a non-final item");

  a_no_forbidden_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_valid |->
      out_data_o.out_byte != 8'h00 && out_data_o.out_byte != 8'h0d &&
      out_data_o.out_byte != 8'h0a && out_data_o.out_byte != 8'h7f)
    else $error("forbidden byte emitted");

  a_zero_when_idle_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_valid |-> out_data_o.out_byte == 8'h00)
    else $error("stale byte on result without data");

  a_full_pipe_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && in_valid_q |-> in_stall_o)
    else $error("input taken while both registers are held");
`endif

endmodule
